@@ hw/rtl/crcdf_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the packet deframer.
// No dependencies; crcdf_payload_ram, crcdf_parser and the deframer top use this package.
`timescale 1ns / 1ps
`default_nettype none

package crcdf_pkg;

  localparam int MaxPayloadBytes = 255;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // configuration register indexes
  localparam logic [0:0] CFG_MAGIC_FIRST  = 1'b0;
  localparam logic [0:0] CFG_MAGIC_SECOND = 1'b1;

  typedef enum logic [6:0] {
    PH_MAGIC1 = 7'b0000001,
    PH_MAGIC2 = 7'b0000010,
    PH_LEN    = 7'b0000100,
    PH_HDR    = 7'b0001000,
    PH_PAY    = 7'b0010000,
    PH_CRCL   = 7'b0100000,
    PH_CRCH   = 7'b1000000
  } phase_t;

  // header view presented with every result beat
  typedef struct packed {
    logic       ready;
    logic [7:0] length;
    logic [7:0] sequence_v;
    logic [7:0] system_v;
    logic [7:0] message_v;
  } hdr_t;

  // payload store write request
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } pay_wr_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crcdf_ifs.sv @@
// Valid/ready channel interfaces for the deframer input and result beats.
// Depends on nothing; used by crc16_packet_deframer_top.
`timescale 1ns / 1ps
`default_nettype none

interface crcdf_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source(output valid, operation, rx_byte, read_index, input ready);
  modport sink(input valid, operation, rx_byte, read_index, output ready);
endinterface

interface crcdf_out_if;
  logic       valid;
  logic       ready;
  logic       frame_ready;
  logic [7:0] frame_length;
  logic [7:0] sequence_res;
  logic [7:0] system_id;
  logic [7:0] message_id;
  logic [7:0] read_data;
  logic       read_in_range;

  modport source(output valid, frame_ready, frame_length, sequence_res, system_id,
                 message_id, read_data, read_in_range, input ready);
  modport sink(input valid, frame_ready, frame_length, sequence_res, system_id,
               message_id, read_data, read_in_range, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crcdf_payload_ram.sv @@
// Payload byte store: one write port, one registered read port.
// Depends on crcdf_pkg for the write request struct.
`timescale 1ns / 1ps
`default_nettype none

module crcdf_payload_ram #(
  parameter int MAX_PAYLOAD_BYTES = crcdf_pkg::MaxPayloadBytes
) (
  input  wire                     clk,
  input  crcdf_pkg::pay_wr_t      wr,
  input  wire                     rd_en,
  input  wire  [7:0]              rd_addr,
  output logic [7:0]              rd_data_r
);

  localparam int AddrW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

  logic [7:0] mem [MAX_PAYLOAD_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AddrW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[AddrW-1:0]];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/crcdf_parser.sv @@
// Frame parser: phase machine, header registers, running CRC and ready flag.
// Depends on crcdf_pkg; drives payload store writes.
`timescale 1ns / 1ps
`default_nettype none

module crcdf_parser #(
  parameter int MAX_PAYLOAD_BYTES = crcdf_pkg::MaxPayloadBytes
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   take_en,
  input  wire  [7:0]            rx_byte,
  input  wire  [7:0]            magic_first,
  input  wire  [7:0]            magic_second,
  output crcdf_pkg::hdr_t       hdr_nxt,
  output crcdf_pkg::pay_wr_t    pay_wr
);

  localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD_BYTES);

  crcdf_pkg::phase_t phase_r, phase_nxt;
  crcdf_pkg::hdr_t   hdr_r;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  stage_seq_r, stage_seq_nxt;
  logic [7:0]  stage_sys_r, stage_sys_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] crc_upd;
  logic [8:0]  cnt_inc;

  assign crc_upd = crcdf_pkg::crc_byte(crc_r, rx_byte);
  assign cnt_inc = {1'b0, cnt_r} + 9'd1;

  always_comb begin
    phase_nxt     = phase_r;
    hdr_nxt       = hdr_r;
    cnt_nxt       = cnt_r;
    stage_seq_nxt = stage_seq_r;
    stage_sys_nxt = stage_sys_r;
    crc_nxt       = crc_r;
    crc_lo_nxt    = crc_lo_r;
    pay_wr.en     = 1'b0;
    pay_wr.addr   = cnt_r;
    pay_wr.data   = rx_byte;
    if (take_en) begin
      case (phase_r)
        crcdf_pkg::PH_MAGIC1: begin
          if (rx_byte == magic_first) begin
            // new frame start: drop the held frame
            hdr_nxt       = '0;
            cnt_nxt       = '0;
            stage_seq_nxt = '0;
            stage_sys_nxt = '0;
            crc_nxt       = crcdf_pkg::CrcInit;
            crc_lo_nxt    = '0;
            phase_nxt     = crcdf_pkg::PH_MAGIC2;
          end
        end
        crcdf_pkg::PH_MAGIC2: begin
          phase_nxt = (rx_byte == magic_second) ? crcdf_pkg::PH_LEN : crcdf_pkg::PH_MAGIC1;
        end
        crcdf_pkg::PH_LEN: begin
          hdr_nxt.length = rx_byte;
          crc_nxt        = crc_upd;
          cnt_nxt        = '0;
          phase_nxt      = crcdf_pkg::PH_HDR;
        end
        crcdf_pkg::PH_HDR: begin
          crc_nxt = crc_upd;
          if (cnt_r == 8'd0) begin
            stage_seq_nxt = rx_byte;
            cnt_nxt       = 8'd1;
          end else if (cnt_r == 8'd1) begin
            stage_sys_nxt = rx_byte;
            cnt_nxt       = 8'd2;
          end else begin
            hdr_nxt.sequence_v = stage_seq_r;
            hdr_nxt.system_v   = stage_sys_r;
            hdr_nxt.message_v  = rx_byte;
            cnt_nxt            = '0;
            if ({1'b0, hdr_r.length} > MaxLen) begin
              phase_nxt = crcdf_pkg::PH_MAGIC1;
            end else if (hdr_r.length == 8'd0) begin
              phase_nxt = crcdf_pkg::PH_CRCL;
            end else begin
              phase_nxt = crcdf_pkg::PH_PAY;
            end
          end
        end
        crcdf_pkg::PH_PAY: begin
          crc_nxt   = crc_upd;
          pay_wr.en = ({1'b0, cnt_r} < MaxLen);
          cnt_nxt   = cnt_inc[7:0];
          if (cnt_inc >= {1'b0, hdr_r.length}) begin
            phase_nxt = crcdf_pkg::PH_CRCL;
          end
        end
        crcdf_pkg::PH_CRCL: begin
          crc_lo_nxt = rx_byte;
          phase_nxt  = crcdf_pkg::PH_CRCH;
        end
        crcdf_pkg::PH_CRCH: begin
          if ({rx_byte, crc_lo_r} == crc_r) begin
            hdr_nxt.ready = 1'b1;
          end
          phase_nxt = crcdf_pkg::PH_MAGIC1;
        end
        default: begin
          phase_nxt = crcdf_pkg::PH_MAGIC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= crcdf_pkg::PH_MAGIC1;
      hdr_r       <= '0;
      cnt_r       <= '0;
      stage_seq_r <= '0;
      stage_sys_r <= '0;
      crc_r       <= crcdf_pkg::CrcInit;
      crc_lo_r    <= '0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_r       <= hdr_nxt;
      cnt_r       <= cnt_nxt;
      stage_seq_r <= stage_seq_nxt;
      stage_sys_r <= stage_sys_nxt;
      crc_r       <= crc_nxt;
      crc_lo_r    <= crc_lo_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/crc16_packet_deframer_top.sv @@
// Packet deframer: magic header, length, sequence, ids, payload, CRC-16.
// A beat accepted on in_ch registers into stage 1 (parser state, header snapshot, payload
// store read); it then loads the result register once that register is free or draining.
// Throughput: one beat per cycle while out_ch.ready keeps the result register draining.
// Reset (rst_n, synchronous, active low) clears magic values, header, CRC and
// handshake state; the payload store is not cleared.
// Depends on crcdf_pkg, crcdf_ifs, crcdf_parser and crcdf_payload_ram.
`timescale 1ns / 1ps
`default_nettype none

module crc16_packet_deframer_top #(
  parameter int MAX_PAYLOAD_BYTES = crcdf_pkg::MaxPayloadBytes
) (
  input  wire               clk,
  input  wire               rst_n,
  crcdf_in_if.sink          in_ch,
  crcdf_out_if.source       out_ch,
  input  wire               cfg_we,
  input  wire  [0:0]        cfg_index,
  input  wire  [7:0]        cfg_wdata
);

  localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD_BYTES);

  logic [7:0] magic_first_r, magic_second_r;

  logic               in_acc, take_en, rd_en, rd_in_range;
  logic               s1_valid_r, s1_adv;
  crcdf_pkg::hdr_t    hdr_nxt;
  crcdf_pkg::hdr_t    s1_hdr_r;
  logic               s1_inr_r;
  crcdf_pkg::pay_wr_t pay_wr;
  logic [7:0]         rd_data_r;
  logic               out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= '0;
      magic_second_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        crcdf_pkg::CFG_MAGIC_FIRST:  magic_first_r  <= cfg_wdata;
        crcdf_pkg::CFG_MAGIC_SECOND: magic_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1 advances when the output register is free or being drained
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign take_en     = in_acc && !in_ch.operation;

  // reads leave state untouched, so the next header equals the current one
  assign rd_in_range = hdr_nxt.ready &&
                       (in_ch.read_index < hdr_nxt.length) &&
                       ({1'b0, in_ch.read_index} < MaxLen);
  assign rd_en = in_acc && in_ch.operation && rd_in_range;

  crcdf_parser #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .take_en      (take_en),
    .rx_byte      (in_ch.rx_byte),
    .magic_first  (magic_first_r),
    .magic_second (magic_second_r),
    .hdr_nxt      (hdr_nxt),
    .pay_wr       (pay_wr)
  );

  crcdf_payload_ram #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk       (clk),
    .wr        (pay_wr),
    .rd_en     (rd_en),
    .rd_addr   (in_ch.read_index),
    .rd_data_r (rd_data_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hdr_r <= hdr_nxt;
      s1_inr_r <= in_ch.operation && rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_adv || (out_valid_r && !out_ch.ready);
    end
  end

  // load the result beat; mask read data for out-of-range reads
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch.frame_ready   <= s1_hdr_r.ready;
      out_ch.frame_length  <= s1_hdr_r.length;
      out_ch.sequence_res  <= s1_hdr_r.sequence_v;
      out_ch.system_id     <= s1_hdr_r.system_v;
      out_ch.message_id    <= s1_hdr_r.message_v;
      out_ch.read_data     <= s1_inr_r ? rd_data_r : 8'd0;
      out_ch.read_in_range <= s1_inr_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

@@ tb/tb_crc16_packet_deframer_top.sv @@
// Self-checking bench for crc16_packet_deframer_top: random and directed beats, with a
// predictor of the framer, header latching, CRC-16 check and payload reads.
// Depends on crcdf_pkg, crcdf_ifs and the deframer RTL.
`timescale 1ns / 1ps

module tb_crc16_packet_deframer_top;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_READ    = 1'b1;
  localparam int   IdlePct    = 37;
  localparam int   HoldCycles = 300;
  localparam int   BeatTarget = 880;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } rx_beat_t;

  typedef struct packed {
    logic       frame_ready;
    logic [7:0] frame_length;
    logic [7:0] sequence_res;
    logic [7:0] system_id;
    logic [7:0] message_id;
    logic [7:0] read_data;
    logic       read_in_range;
  } deframe_view_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_wdata;

  crcdf_in_if  in_ch();
  crcdf_out_if out_ch();

  crc16_packet_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rx_beat_t      pending_beats[$];
  deframe_view_t predicted_views[$];
  rx_beat_t      offer;
  int            beats_queued = 0;
  int            mismatches = 0;
  int            views_seen = 0;
  bit            steady = 1'b0;
  int            hold_trig = 0;
  int            hold_done = 0;
  int            hold_left = 0;

  // predictor state
  logic [7:0]        magic_first_q = 8'h00;
  logic [7:0]        magic_second_q = 8'h00;
  crcdf_pkg::phase_t p_phase = crcdf_pkg::PH_MAGIC1;
  logic [8:0]        p_count = '0;
  logic [7:0]        p_len = '0;
  logic [7:0]        p_seq = '0;
  logic [7:0]        p_sys = '0;
  logic [7:0]        p_msg = '0;
  logic [7:0]        p_stage_seq = '0;
  logic [7:0]        p_stage_sys = '0;
  logic [15:0]       p_crc = crcdf_pkg::CrcInit;
  logic [15:0]       p_rx_crc = '0;
  logic              p_ready = 1'b0;
  logic [7:0]        p_pay [0:crcdf_pkg::MaxPayloadBytes-1];

  // bit-serial form: feed one data bit into the top of the register per step
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[15] ^ d[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? crcdf_pkg::CrcPoly : 16'h0000);
    end
    return acc;
  endfunction

  task automatic clear_frame_state();
    p_count = '0;
    p_len = '0;
    p_seq = '0;
    p_sys = '0;
    p_msg = '0;
    p_stage_seq = '0;
    p_stage_sys = '0;
    p_crc = crcdf_pkg::CrcInit;
    p_rx_crc = '0;
    p_ready = 1'b0;
  endtask

  task automatic take_rx(input logic [7:0] b);
    case (p_phase)
      crcdf_pkg::PH_MAGIC1: begin
        if (b == magic_first_q) begin
          clear_frame_state();
          p_phase = crcdf_pkg::PH_MAGIC2;
        end
      end
      crcdf_pkg::PH_MAGIC2: begin
        p_phase = (b == magic_second_q) ? crcdf_pkg::PH_LEN : crcdf_pkg::PH_MAGIC1;
      end
      crcdf_pkg::PH_LEN: begin
        p_len = b;
        p_crc = crc_step(p_crc, b);
        p_count = '0;
        p_phase = crcdf_pkg::PH_HDR;
      end
      crcdf_pkg::PH_HDR: begin
        p_crc = crc_step(p_crc, b);
        if (p_count == 0) begin
          p_stage_seq = b;
          p_count = 9'd1;
        end else if (p_count == 1) begin
          p_stage_sys = b;
          p_count = 9'd2;
        end else begin
          // ids appear together with the message id byte
          p_seq = p_stage_seq;
          p_sys = p_stage_sys;
          p_msg = b;
          p_count = '0;
          p_phase = (p_len == 0) ? crcdf_pkg::PH_CRCL : crcdf_pkg::PH_PAY;
        end
      end
      crcdf_pkg::PH_PAY: begin
        p_crc = crc_step(p_crc, b);
        if (p_count < crcdf_pkg::MaxPayloadBytes) p_pay[p_count] = b;
        p_count = p_count + 9'd1;
        if (p_count >= {1'b0, p_len}) p_phase = crcdf_pkg::PH_CRCL;
      end
      crcdf_pkg::PH_CRCL: begin
        p_rx_crc = {8'h00, b};
        p_phase = crcdf_pkg::PH_CRCH;
      end
      crcdf_pkg::PH_CRCH: begin
        p_rx_crc[15:8] = b;
        if (p_rx_crc == p_crc) p_ready = 1'b1;
        p_phase = crcdf_pkg::PH_MAGIC1;
      end
      default: begin
        p_phase = crcdf_pkg::PH_MAGIC1;
      end
    endcase
  endtask

  task automatic predict_view(input rx_beat_t t);
    deframe_view_t v;
    v = '0;
    if (t.op == OP_RECEIVE) begin
      take_rx(t.rx_byte);
    end else if (p_ready && t.read_index < p_len) begin
      v.read_data = p_pay[t.read_index];
      v.read_in_range = 1'b1;
    end
    v.frame_ready = p_ready;
    v.frame_length = p_len;
    v.sequence_res = p_seq;
    v.system_id = p_sys;
    v.message_id = p_msg;
    predicted_views = {predicted_views, v};
  endtask

  // input driver: predict on accept, then offer the next planned beat or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_view(offer);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          offer = pending_beats.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= offer.op;
          in_ch.rx_byte <= offer.rx_byte;
          in_ch.read_index <= offer.read_index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    deframe_view_t got;
    deframe_view_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.frame_ready = out_ch.frame_ready;
        got.frame_length = out_ch.frame_length;
        got.sequence_res = out_ch.sequence_res;
        got.system_id = out_ch.system_id;
        got.message_id = out_ch.message_id;
        got.read_data = out_ch.read_data;
        got.read_in_range = out_ch.read_in_range;
        if (predicted_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat %0d arrived with nothing expected", views_seen);
        end else begin
          want = predicted_views.pop_front();
          if (got.frame_ready !== want.frame_ready || got.frame_length !== want.frame_length ||
              got.sequence_res !== want.sequence_res || got.system_id !== want.system_id ||
              got.message_id !== want.message_id || got.read_data !== want.read_data ||
              got.read_in_range !== want.read_in_range) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat %0d: exp rdy=%b len=%h seq=%h sys=%h msg=%h data=%h inr=%b",
                       views_seen, want.frame_ready, want.frame_length, want.sequence_res,
                       want.system_id, want.message_id, want.read_data, want.read_in_range);
              $display("beat %0d: got rdy=%b len=%h seq=%h sys=%h msg=%h data=%h inr=%b",
                       views_seen, got.frame_ready, got.frame_length, got.sequence_res,
                       got.system_id, got.message_id, got.read_data, got.read_in_range);
            end
          end
        end
        views_seen++;
      end
      if (hold_trig != hold_done) begin
        hold_done = hold_trig;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  task automatic stash_beat(input rx_beat_t t);
    pending_beats = {pending_beats, t};
    beats_queued++;
  endtask

  task automatic push_rx(input logic [7:0] b);
    rx_beat_t t;
    t.op = OP_RECEIVE;
    t.rx_byte = b;
    t.read_index = 8'($urandom_range(254));
    stash_beat(t);
  endtask

  task automatic push_read(input int idx);
    rx_beat_t t;
    t.op = OP_READ;
    t.rx_byte = 8'($urandom);
    t.read_index = 8'(idx);
    stash_beat(t);
  endtask

  task automatic queue_frame(input int len, input logic [7:0] seq_b, input logic [7:0] sys_b,
                             input logic [7:0] msg_b, input bit bad_crc, input bit bad_magic);
    logic [15:0] acc;
    logic [7:0]  pb;
    acc = crcdf_pkg::CrcInit;
    push_rx(magic_first_q);
    push_rx(bad_magic ? (magic_second_q ^ 8'(1 + $urandom_range(254))) : magic_second_q);
    push_rx(8'(len));
    acc = crc_step(acc, 8'(len));
    push_rx(seq_b);
    acc = crc_step(acc, seq_b);
    push_rx(sys_b);
    acc = crc_step(acc, sys_b);
    push_rx(msg_b);
    acc = crc_step(acc, msg_b);
    for (int k = 0; k < len; k++) begin
      // sprinkle the first magic value into the payload; it must not restart the frame
      pb = ($urandom_range(9) == 0) ? magic_first_q : 8'($urandom);
      push_rx(pb);
      acc = crc_step(acc, pb);
    end
    if (bad_crc) acc = acc ^ 16'(1 << $urandom_range(15));
    push_rx(acc[7:0]);
    push_rx(acc[15:8]);
  endtask

  task automatic set_magics(input logic [7:0] m1, input logic [7:0] m2);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= crcdf_pkg::CFG_MAGIC_FIRST;
    cfg_wdata <= m1;
    @(posedge clk);
    cfg_index <= crcdf_pkg::CFG_MAGIC_SECOND;
    cfg_wdata <= m2;
    @(posedge clk);
    cfg_we <= 1'b0;
    magic_first_q = m1;
    magic_second_q = m2;
    @(negedge clk);
  endtask

  // hold until every planned beat is accepted and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_ch.valid || predicted_views.size() != 0);
  endtask

  initial begin
    int         phase_no;
    int         goal;
    int         last_len;
    int         pick;
    logic [7:0] m1;
    logic [7:0] m2;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = crcdf_pkg::CFG_MAGIC_FIRST;
    cfg_wdata = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_RECEIVE;
    in_ch.rx_byte = 8'h00;
    in_ch.read_index = 8'h00;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset magics (both zero): read while empty, then a zero-length frame
    push_read(254);
    queue_frame(0, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
    wait_idle();

    // wrong second magic is not rechecked; a short frame and reads around its edge
    set_magics(8'hFF, 8'h55);
    push_rx(8'hFF);
    push_rx(8'hFF);
    push_rx(8'h55);
    queue_frame(3, 8'h00, 8'hFF, 8'h80, 1'b0, 1'b0);
    push_read(0);
    push_read(2);
    push_read(3);
    wait_idle();

    phase_no = 0;
    last_len = 3;
    while (beats_queued < BeatTarget) begin
      case (phase_no)
        0: begin m1 = 8'h00; m2 = 8'hFF; end
        1: begin m1 = 8'hFF; m2 = 8'hFF; end
        default: begin m1 = 8'($urandom); m2 = 8'($urandom); end
      endcase
      set_magics(m1, m2);
      steady = (phase_no == 1 || phase_no == 2);
      goal = beats_queued + 140;
      if (phase_no == 3) begin
        queue_frame(crcdf_pkg::MaxPayloadBytes, 8'($urandom), 8'($urandom), 8'($urandom),
                    1'b0, 1'b0);
        push_read(254);
        push_read(0);
        last_len = crcdf_pkg::MaxPayloadBytes;
      end
      while (beats_queued < goal) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          last_len = ($urandom_range(4) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
          queue_frame(last_len, 8'($urandom), 8'($urandom), 8'($urandom),
                      $urandom_range(6) == 0, $urandom_range(11) == 0);
        end else if (pick < 85) begin
          if ($urandom_range(3) == 0) push_read($urandom_range(254));
          else push_read($urandom_range(last_len < 254 ? last_len : 254));
        end else begin
          push_rx(8'($urandom));
        end
      end
      // stall the receiver while the sender keeps offering
      if (phase_no == 2) hold_trig++;
      wait_idle();
      steady = 1'b0;
      phase_no++;
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && predicted_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/crcdf_pkg.sv
hw/rtl/crcdf_ifs.sv
hw/rtl/crcdf_payload_ram.sv
hw/rtl/crcdf_parser.sv
hw/rtl/crc16_packet_deframer_top.sv
tb/tb_crc16_packet_deframer_top.sv
